>>> sv/light_pulse_sequence_interpreter_defines.svh
// ---------------------------------------------------------------------------
// light pulse sequence interpreter: assertion macros
// implication checks used by the interpreter modules; empty for synthesis
// ---------------------------------------------------------------------------
`ifndef LIGHT_PULSE_SEQUENCE_INTERPRETER_DEFINES_SVH
`define LIGHT_PULSE_SEQUENCE_INTERPRETER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LPSI_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("lpsi: same-cycle check failed");

// next-cycle implication
`define LPSI_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("lpsi: next-cycle check failed");

`else

`define LPSI_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define LPSI_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> sv/lpsi_pkg.sv
// ---------------------------------------------------------------------------
// lpsi_pkg
// shared codes, constants and the job record of the sequence interpreter
// ---------------------------------------------------------------------------
`default_nettype none

package lpsi_pkg;

    // result command codes
    localparam logic [1:0] CMD_DETECT = 2'd0;
    localparam logic [1:0] CMD_LASER  = 2'd1;
    localparam logic [1:0] CMD_LEVEL  = 2'd2;
    localparam logic [1:0] CMD_WAIT   = 2'd3;

    // configuration register indexes
    localparam logic CFG_FULL_SCALE = 1'b0;
    localparam logic CFG_RESTING    = 1'b1;

    // script characters
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_L    = 8'h4C;

    localparam int VALUE_W = 32;

    // level = floor((full_scale * thousandths + 50000) / 100000), max 255
    localparam logic [39:0] LVL_ROUND     = 40'd50000;
    localparam logic [39:0] LVL_SAT_LIMIT = 40'd25600000;
    localparam int          PROD_W        = 25;
    // floor(p / 100000) == (p * RECIP_M) >> RECIP_SHIFT for p < 2**25
    localparam int          RECIP_SHIFT   = 42;
    localparam logic [25:0] RECIP_M       = 26'd43980466;

    // weight of a decimal place after the dot
    function automatic logic [6:0] fraction_weight(input logic [1:0] fd);
        logic [6:0] w;
        unique case (fd)
            2'd0:    w = 7'd100;
            2'd1:    w = 7'd10;
            default: w = 7'd1;
        endcase
        return w;
    endfunction

    // results caused by one character
    typedef struct packed {
        logic               wait_en;   // wait of value first
        logic               tail_en;   // then a tail command
        logic [1:0]         tail_cmd;
        logic               tail_calc; // level computed from value
        logic [VALUE_W-1:0] value;
    } t_job;

endpackage

`default_nettype wire

>>> sv/lpsi_parse.sv
// ---------------------------------------------------------------------------
// lpsi_parse
// number accumulator and character decode; gives the job of each character
// ---------------------------------------------------------------------------
`default_nettype none

`include "light_pulse_sequence_interpreter_defines.svh"

module lpsi_parse (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire logic [7:0]     i_char_code,
    output lpsi_pkg::t_job      o_job,
    output logic                o_job_en
);
    import lpsi_pkg::*;

    logic               r_in_number, n_in_number;
    logic               r_dot_seen, n_dot_seen;
    logic               r_frozen, n_frozen;
    logic [1:0]         r_frac_digits, n_frac_digits;
    logic [VALUE_W-1:0] r_value, n_value;

    logic       is_digit;
    logic [7:0] digit_diff;
    logic [3:0] digit;
    logic [35:0] int_sum;
    logic [32:0] frac_sum;
    t_job       job;

    // digit decode and both accumulate paths
    assign is_digit   = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign digit_diff = i_char_code - CH_ZERO;
    assign digit      = digit_diff[3:0];
    assign int_sum    = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1)
                      + (36'(digit) * 36'd1000);
    assign frac_sum   = {1'b0, r_value}
                      + (33'(digit) * 33'(fraction_weight(r_frac_digits)));

    // next number state and job
    always_comb begin
        n_in_number   = r_in_number;
        n_dot_seen    = r_dot_seen;
        n_frozen      = r_frozen;
        n_frac_digits = r_frac_digits;
        n_value       = r_value;
        job           = '0;
        job.value     = r_value;
        if (is_digit) begin
            n_in_number = 1'b1;
            if (!r_frozen) begin
                if (!r_dot_seen) begin
                    n_value = (int_sum[35:32] != 4'd0) ? '1 : int_sum[31:0];
                end else if (r_frac_digits != 2'd3) begin
                    n_value       = frac_sum[32] ? '1 : frac_sum[31:0];
                    n_frac_digits = r_frac_digits + 2'd1;
                end
            end
        end else if (i_char_code == CH_DOT) begin
            if (r_in_number && r_dot_seen) begin
                n_frozen = 1'b1;
            end
            n_in_number = 1'b1;
            n_dot_seen  = 1'b1;
        end else begin
            // end of a number
            if (r_in_number) begin
                n_in_number   = 1'b0;
                n_dot_seen    = 1'b0;
                n_frozen      = 1'b0;
                n_frac_digits = 2'd0;
                n_value       = '0;
                if (i_char_code == CH_BANG) begin
                    job.tail_en   = 1'b1;
                    job.tail_cmd  = CMD_LEVEL;
                    job.tail_calc = 1'b1;
                end else begin
                    job.wait_en = 1'b1;
                end
            end
            // the character itself
            if (!(r_in_number && (i_char_code == CH_BANG))) begin
                priority if (i_char_code == CH_D) begin
                    job.tail_en  = 1'b1;
                    job.tail_cmd = CMD_DETECT;
                end else if (i_char_code == CH_L) begin
                    job.tail_en  = 1'b1;
                    job.tail_cmd = CMD_LASER;
                end else if (i_char_code == CH_NUL) begin
                    job.tail_en   = 1'b1;
                    job.tail_cmd  = CMD_LEVEL;
                    n_in_number   = 1'b0;
                    n_dot_seen    = 1'b0;
                    n_frozen      = 1'b0;
                    n_frac_digits = 2'd0;
                    n_value       = '0;
                end else begin
                    job.tail_en = 1'b0;
                end
            end
        end
    end

    assign o_job    = job;
    assign o_job_en = job.wait_en | job.tail_en;

    // number state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number   <= 1'b0;
            r_dot_seen    <= 1'b0;
            r_frozen      <= 1'b0;
            r_frac_digits <= 2'd0;
            r_value       <= '0;
        end else if (i_take) begin
            r_in_number   <= n_in_number;
            r_dot_seen    <= n_dot_seen;
            r_frozen      <= n_frozen;
            r_frac_digits <= n_frac_digits;
            r_value       <= n_value;
        end
    end

    // a frozen number always came from a dotted run
    `LPSI_ASSERT_IMPL(a_frozen_dotted, i_clk, i_rst_n, r_frozen, r_dot_seen && r_in_number)
    // decimals are only counted after the dot
    `LPSI_ASSERT_IMPL(a_frac_after_dot, i_clk, i_rst_n, r_frac_digits != 2'd0, r_dot_seen)
    // a wait only comes from a pending number
    `LPSI_ASSERT_IMPL(a_wait_needs_number, i_clk, i_rst_n, job.wait_en, r_in_number)

endmodule

`default_nettype wire

>>> sv/light_pulse_sequence_interpreter.sv
// ---------------------------------------------------------------------------
// light_pulse_sequence_interpreter
// turns script characters into trigger, level and wait commands
// ---------------------------------------------------------------------------
// usage:
//   input channel i_valid / o_stall carries one script character per item;
//   output channel o_valid / i_stall carries one command per item, with
//   o_last_of_run marking the final command caused by a character. config
//   writes (i_cfg_valid, o_cfg_ready always high) set full scale (index 0)
//   and resting level (index 1), by user rule only while idle (unchecked).
// timing:
//   a character is accepted every cycle while the pipe flows; a character
//   that gives commands passes stages 1 and 2 into stage 3, where its
//   first command is shown. digits and dots only update the number state;
//   an ignored character gives a wait only when it ends a number. one
//   command leaves per cycle while i_stall is low, so a character with two
//   commands (wait followed by trigger or level) holds the output register
//   until both have left; the level path costs one 8x32 multiply and one
//   25x26 reciprocal multiply, each in a stage of its own.
// reset: number state cleared, full scale 255, resting level 0, pipe empty.
// stall: i_stall holds the output command; the stages behind it fill and
//   then o_stall rises until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

`include "light_pulse_sequence_interpreter_defines.svh"

module light_pulse_sequence_interpreter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // script characters
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_code,
    // commands
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_command,
    output logic [31:0]      o_amount,
    output logic             o_last_of_run,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import lpsi_pkg::*;

    logic [7:0] r_full_scale;
    logic [7:0] r_resting;

    logic take;
    t_job job;
    logic job_en;

    // stage 1: job
    logic r1_valid;
    t_job r1_job;
    // stage 2: job and rounded product
    logic               r2_valid;
    t_job               r2_job;
    logic [PROD_W-1:0]  r2_prod;
    logic               r2_sat;
    // stage 3: output pair
    logic               r3_valid;
    logic               r3_two;
    logic               r3_idx;
    logic [1:0]         r3_cmd0, r3_cmd1;
    logic [VALUE_W-1:0] r3_amt0, r3_amt1;

    logic s2_load, s3_load, s3_done, out_take;
    logic [39:0] prod;
    logic [50:0] recip;
    logic [7:0]  level;
    logic [VALUE_W-1:0] tail_amt;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= 8'd255;
            r_resting    <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FULL_SCALE: r_full_scale <= i_cfg_data;
                CFG_RESTING:    r_resting    <= i_cfg_data;
                default:        r_resting    <= r_resting;
            endcase
        end
    end

    // character decode and number state
    assign take = i_valid && !o_stall;

    lpsi_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_code (i_char_code),
        .o_job       (job),
        .o_job_en    (job_en)
    );

    // stage flow
    assign out_take = r3_valid && !i_stall;
    assign s3_done  = out_take && o_last_of_run;
    assign s3_load  = r2_valid && (!r3_valid || s3_done);
    assign s2_load  = r1_valid && (!r2_valid || s3_load);
    assign o_stall  = r1_valid && !s2_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r3_idx   <= 1'b0;
        end else begin
            r1_valid <= (r1_valid && !s2_load) || (take && job_en);
            r2_valid <= (r2_valid && !s3_load) || s2_load;
            r3_valid <= (r3_valid && !s3_done) || s3_load;
            if (s3_load) begin
                r3_idx <= 1'b0;
            end else if (out_take && !o_last_of_run) begin
                r3_idx <= 1'b1;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (take && job_en) begin
            r1_job <= job;
        end
    end

    // full scale times value, plus half of the divisor
    assign prod = (40'(r_full_scale) * 40'(r1_job.value)) + LVL_ROUND;

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r2_job  <= r1_job;
            r2_prod <= prod[PROD_W-1:0];
            r2_sat  <= (prod >= LVL_SAT_LIMIT);
        end
    end

    // divide by 100000 through the reciprocal, saturate at 255
    assign recip = 51'(r2_prod) * 51'(RECIP_M);
    assign level = r2_sat ? 8'hFF : recip[RECIP_SHIFT +: 8];

    always_comb begin
        priority if (r2_job.tail_calc) begin
            tail_amt = 32'(level);
        end else if (r2_job.tail_cmd == CMD_LEVEL) begin
            tail_amt = 32'(r_resting);
        end else begin
            tail_amt = '0;
        end
    end

    // output pair register
    always_ff @(posedge i_clk) begin
        if (s3_load) begin
            r3_two  <= r2_job.wait_en && r2_job.tail_en;
            r3_cmd0 <= r2_job.wait_en ? CMD_WAIT : r2_job.tail_cmd;
            r3_amt0 <= r2_job.wait_en ? r2_job.value : tail_amt;
            r3_cmd1 <= r2_job.tail_cmd;
            r3_amt1 <= tail_amt;
        end
    end

    assign o_valid       = r3_valid;
    assign o_command     = r3_idx ? r3_cmd1 : r3_cmd0;
    assign o_amount      = r3_idx ? r3_amt1 : r3_amt0;
    assign o_last_of_run = !r3_two || r3_idx;

    // second slot is only reached for a pair
    `LPSI_ASSERT_IMPL(a_idx_pair, i_clk, i_rst_n, r3_valid && r3_idx, r3_two)
    // after the first of a pair leaves, the second is shown next
    `LPSI_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, out_take && !o_last_of_run, o_valid && o_last_of_run && (r3_idx == 1'b1))
    // triggers carry no amount
    `LPSI_ASSERT_IMPL(a_trigger_zero, i_clk, i_rst_n, o_valid && ((o_command == CMD_DETECT) || (o_command == CMD_LASER)), o_amount == '0)

endmodule

`default_nettype wire

>>> bench/light_pulse_sequence_interpreter_tb.sv
// ---------------------------------------------------------------------------
// light_pulse_sequence_interpreter_tb
// Drives script characters into the interpreter and checks every command
// that comes out against an in-bench interpreter model. Directed scripts
// cover triggers, levels, waits and the end of a script. Random scripts run
// under several full-scale and resting-level settings, with random idle
// cycles on both sides, a long receiver hold-off and a sender pause.
// ---------------------------------------------------------------------------
`default_nettype none

module light_pulse_sequence_interpreter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lpsi_pkg::*;

    localparam int SETTLE_CYCLES = 12;    // covers pipe depth plus a two-command item
    localparam int STALL_LIMIT   = 4000;  // cycles without any handshake
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 100;

    typedef struct {
        logic [1:0]  command;
        logic [31:0] amount;
        logic        last;
    } t_cmd;

    // dut ports
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [7:0]  i_char_code   = 8'd0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [1:0]  o_command;
    logic [31:0] o_amount;
    logic        o_last_of_run;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index   = 1'b0;
    logic [7:0]  i_cfg_data    = 8'd0;

    // interpreter model state
    logic [7:0]  full_scale = 8'd255;
    logic [7:0]  rest_level = 8'd0;
    logic        num_active;
    logic        num_has_dot;
    logic        num_frozen;
    logic [1:0]  num_decimals;
    logic [31:0] num_thousandths;

    t_cmd        cmds_due[$];
    int          mismatches    = 0;
    int          script_chars  = 0;
    bit          src_idle_en   = 1'b1;
    bit          sink_idle_en  = 1'b1;
    int          hold_request  = 0;

    light_pulse_sequence_interpreter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_code   (i_char_code),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_command     (o_command),
        .o_amount      (o_amount),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // interpreter model
    // ---------------------------------------------------------------------

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [31:0] level_from_percent(input logic [31:0] v);
        logic [63:0] q;
        q = (64'(full_scale) * 64'(v) + 64'd50000) / 64'd100000;
        return (q > 64'd255) ? 32'd255 : q[31:0];
    endfunction

    task automatic clear_number();
        num_active      = 1'b0;
        num_has_dot     = 1'b0;
        num_frozen      = 1'b0;
        num_decimals    = 2'd0;
        num_thousandths = 32'd0;
    endtask

    task automatic accumulate_digit(input logic [3:0] d);
        logic [63:0] v;
        v = 64'(num_thousandths);
        if (num_frozen) return;
        if (!num_has_dot) begin
            v = v * 64'd10 + 64'(d) * 64'd1000;
        end else begin
            if (num_decimals == 2'd3) return;
            case (num_decimals)
                2'd0:    v = v + 64'(d) * 64'd100;
                2'd1:    v = v + 64'(d) * 64'd10;
                default: v = v + 64'(d);
            endcase
            num_decimals = num_decimals + 2'd1;
        end
        num_thousandths = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endtask

    // work out the commands one character causes and queue them
    task automatic interpret_char(input logic [7:0] c);
        t_cmd res[2];
        int   n;
        n = 0;
        if (is_digit(c)) begin
            num_active = 1'b1;
            accumulate_digit(4'(c - CH_ZERO));
            return;
        end
        if (c == CH_DOT) begin
            if (num_active && num_has_dot) num_frozen = 1'b1;
            num_active  = 1'b1;
            num_has_dot = 1'b1;
            return;
        end
        if (num_active && c == CH_BANG) begin
            res[0] = '{CMD_LEVEL, level_from_percent(num_thousandths), 1'b0};
            n = 1;
            clear_number();
        end else begin
            // a pending number becomes a wait first
            if (num_active) begin
                res[n] = '{CMD_WAIT, num_thousandths, 1'b0};
                n++;
                clear_number();
            end
            if (c == CH_D) begin
                res[n] = '{CMD_DETECT, 32'd0, 1'b0};
                n++;
            end else if (c == CH_L) begin
                res[n] = '{CMD_LASER, 32'd0, 1'b0};
                n++;
            end else if (c == CH_NUL) begin
                res[n] = '{CMD_LEVEL, 32'(rest_level), 1'b0};
                n++;
                clear_number();
            end
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) cmds_due.push_back(res[i]);
    endtask

    // ---------------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------------

    task automatic send_char(input logic [7:0] c);
        while (src_idle_en && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (o_stall);
        // item taken at this edge
        if (is_digit(c) || c == CH_DOT || num_active || c == CH_D || c == CH_L
                || c == CH_NUL)
            script_chars++;
        interpret_char(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // wait until every command has come out and the pipe has settled
    task automatic quiesce();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (cmds_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] val);
        quiesce();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FULL_SCALE) full_scale = val;
        else rest_level = val;
    endtask

    // ---------------------------------------------------------------------
    // random script pieces
    // ---------------------------------------------------------------------

    task automatic send_random_digit();
        send_char(CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic send_number(input bit broken);
        int whole;
        int frac;
        whole = ($urandom_range(9) == 0) ? $urandom_range(6, 11) : $urandom_range(0, 3);
        if (!broken) begin
            for (int i = 0; i < whole; i++) send_random_digit();
            if (whole == 0 || $urandom_range(1)) begin
                send_char(CH_DOT);
                frac = $urandom_range(0, 5);
                for (int i = 0; i < frac; i++) send_random_digit();
            end
        end else begin
            case ($urandom_range(2))
                // dots only
                0: repeat ($urandom_range(1, 3)) send_char(CH_DOT);
                // second dot freezes, more digits dropped
                1: begin
                    for (int i = 0; i < whole; i++) send_random_digit();
                    send_char(CH_DOT);
                    repeat ($urandom_range(0, 2)) send_random_digit();
                    send_char(CH_DOT);
                    repeat ($urandom_range(0, 3)) begin
                        if ($urandom_range(3) == 0) send_char(CH_DOT);
                        else send_random_digit();
                    end
                end
                // digits and dots mixed
                default: repeat ($urandom_range(3, 8)) begin
                    if ($urandom_range(2) == 0) send_char(CH_DOT);
                    else send_random_digit();
                end
            endcase
        end
    endtask

    task automatic send_terminator();
        int          r;
        logic [7:0]  c;
        r = $urandom_range(99);
        if (r < 40) send_char(CH_BANG);
        else if (r < 55) send_char(CH_D);
        else if (r < 65) send_char(CH_L);
        else if (r < 75) send_char(CH_NUL);
        else begin
            do c = 8'($urandom_range(255)); while (is_digit(c) || c == CH_DOT);
            send_char(c);
        end
    endtask

    task automatic send_random_token();
        int r;
        r = $urandom_range(99);
        if (r < 12) send_char(CH_D);
        else if (r < 22) send_char(CH_L);
        else if (r < 60) begin
            send_number(1'b0);
            send_terminator();
        end else if (r < 68) send_char(CH_NUL);
        else if (r < 78) begin
            send_number(1'b1);
            send_terminator();
        end else send_char(8'($urandom_range(255)));
    endtask

    task automatic run_random_script(input int n_chars);
        int stop_at;
        stop_at = script_chars + n_chars;
        while (script_chars < stop_at) send_random_token();
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    task automatic test_triggers();
        send_char(CH_D);
        send_char(8'hFF);
        send_char(CH_L);
    endtask

    task automatic test_levels();
        send_text("12.5");
        send_char(CH_BANG);
        // far above one hundred percent, value saturates too
        send_text("5000000");
        send_char(CH_BANG);
        // bang outside a number
        send_char(CH_BANG);
    endtask

    task automatic test_waits();
        // lone dots, second dot freezes the value
        send_text("..5");
        send_char(CH_D);
    endtask

    task automatic test_end_of_script();
        // extra decimals dropped, then nul flushes the wait
        send_text(".1234");
        send_char(CH_NUL);
        send_char(CH_NUL);
    endtask

    task automatic test_config_sweep();
        logic [7:0] fs_set[5]   = '{8'd0, 8'd1, 8'd100, 8'd255, 8'd0};
        logic [7:0] rest_set[5] = '{8'd255, 8'd1, 8'd128, 8'd0, 8'd0};
        fs_set[4]   = 8'($urandom_range(255));
        rest_set[4] = 8'($urandom_range(255));
        for (int p = 0; p < 5; p++) begin
            write_register(CFG_FULL_SCALE, fs_set[p]);
            write_register(CFG_RESTING, rest_set[p]);
            run_random_script(80);
        end
    endtask

    task automatic test_no_idle_stretch();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_random_script(100);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_request = HOLD_CYCLES;
        src_idle_en  = 1'b0;
        repeat (30) begin
            if ($urandom_range(1)) send_char(CH_D);
            else send_random_token();
        end
        src_idle_en = 1'b1;
    endtask

    task automatic test_sender_pause();
        run_random_script(30);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (cmds_due.size() != 0);
        run_random_script(30);
    endtask

    // ---------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at %0t: %s want %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // compare each command taken from the block with the oldest one due
    initial begin
        t_cmd head;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (cmds_due.size() == 0) begin
                    report_mismatch("command with none due", 32'd0, 32'(o_command));
                end else begin
                    head = cmds_due.pop_front();
                    if (o_command !== head.command)
                        report_mismatch("command", 32'(head.command), 32'(o_command));
                    if (o_amount !== head.amount)
                        report_mismatch("amount", head.amount, o_amount);
                    if (o_last_of_run !== head.last)
                        report_mismatch("last_of_run", 32'(head.last), 32'(o_last_of_run));
                end
            end
        end
    end

    // receiver stall, with an optional long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= sink_idle_en && ($urandom_range(99) < 38);
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("light_pulse_sequence_interpreter_tb: FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin
        clear_number();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_triggers();
        test_levels();
        test_waits();
        test_end_of_script();
        test_config_sweep();
        test_no_idle_stretch();
        test_backpressure();
        test_sender_pause();

        quiesce();
        if (mismatches == 0) begin
            $display("light_pulse_sequence_interpreter_tb: PASS");
        end else begin
            $display("light_pulse_sequence_interpreter_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/lpsi_pkg.sv
sv/lpsi_parse.sv
sv/light_pulse_sequence_interpreter.sv
bench/light_pulse_sequence_interpreter_tb.sv
